// ----- hdl/bellman_ford_shortest_distance_assert.svh -----
// ----------------------------------------------------------------------------
// bellman_ford_shortest_distance_assert.svh
// assertion macros for the shortest distance block
// ----------------------------------------------------------------------------
`ifndef BELLMAN_FORD_SHORTEST_DISTANCE_ASSERT_SVH
`define BELLMAN_FORD_SHORTEST_DISTANCE_ASSERT_SVH

`ifndef SYNTHESIS
`define BFSD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BFSD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BFSD_ASSERT(lbl, prop, msg)
`define BFSD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- hdl/bfsd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfsd_pkg
// shared constants, types and codes of the shortest distance block
// ----------------------------------------------------------------------------
package bfsd_pkg;

    localparam int MAX_NODES   = 16;
    localparam int WEIGHT_BITS = 16;
    localparam int DIST_BITS   = 24;

    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int CNT_W     = NODE_W + 1;
    localparam int WADDR_W   = 2 * NODE_W;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 2;
    localparam int SUM_W     = ((DIST_BITS > WEIGHT_BITS) ? DIST_BITS : WEIGHT_BITS) + 1;

    localparam logic [CFG_W-1:0] NODE_COUNT_RST  = 5'd16;
    localparam logic [CFG_W-1:0] SOURCE_NODE_RST = 5'd1;
    localparam logic [CFG_W-1:0] DEST_NODE_RST   = 5'd1;

    typedef logic [NODE_W-1:0]              node_t;
    typedef logic [CNT_W-1:0]               cnt_t;
    typedef logic [CFG_W-1:0]               cfg_t;
    typedef logic signed [WEIGHT_BITS-1:0]  weight_t;
    typedef logic signed [DIST_BITS-1:0]    dist_t;
    typedef logic signed [SUM_W-1:0]        sum_t;

    localparam dist_t DIST_MAX = {1'b0, {(DIST_BITS-1){1'b1}}};
    localparam dist_t DIST_MIN = {1'b1, {(DIST_BITS-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NODE_COUNT  = 2'd0,
        CFG_SOURCE_NODE = 2'd1,
        CFG_DEST_NODE   = 2'd2
    } cfg_idx_t;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_INIT   = 5'b00010,
        ST_RUN    = 5'b00100,
        ST_DRAIN  = 5'b01000,
        ST_RESULT = 5'b10000
    } state_t;

    typedef struct packed {
        logic    none;
        weight_t w;
    } wentry_t;

    typedef struct packed {
        logic  inf;
        dist_t d;
    } dentry_t;

    typedef struct packed {
        logic  valid;
        logic  check;
        node_t u;
        node_t v;
    } issue_t;

endpackage

// ----- hdl/bfsd_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfsd_if
// valid/ready channels for matrix entries and distance results
// ----------------------------------------------------------------------------
interface bfsd_in_if;
    import bfsd_pkg::*;

    logic    valid;
    logic    ready;
    node_t   row_index;
    node_t   col_index;
    weight_t edge_weight;
    logic    no_edge;
    logic    last_entry;

    modport source (output valid, output row_index, output col_index, output edge_weight,
                    output no_edge, output last_entry, input ready);
    modport sink   (input valid, input row_index, input col_index, input edge_weight,
                    input no_edge, input last_entry, output ready);
endinterface

interface bfsd_out_if;
    import bfsd_pkg::*;

    logic  valid;
    logic  ready;
    dist_t distance;
    logic  unreachable;
    logic  negative_cycle;

    modport source (output valid, output distance, output unreachable,
                    output negative_cycle, input ready);
    modport sink   (input valid, input distance, input unreachable,
                    input negative_cycle, output ready);
endinterface

// ----- hdl/bfsd_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfsd_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module bfsd_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/bfsd_dist_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfsd_dist_ram
// distance store: two read ports, one write port, infinity flags, forwarding
// ----------------------------------------------------------------------------
module bfsd_dist_ram (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             init,
    input  bfsd_pkg::node_t  a_addr,
    input  bfsd_pkg::node_t  b_addr,
    input  logic             we,
    input  bfsd_pkg::node_t  waddr,
    input  bfsd_pkg::dist_t  wdata,
    output bfsd_pkg::dentry_t a_q,
    output bfsd_pkg::dentry_t b_q
);
    import bfsd_pkg::*;

    dist_t                 mem [MAX_NODES];
    logic [MAX_NODES-1:0]  inf_reg;
    logic [MAX_NODES-1:0]  inf_next;
    dist_t                 a_rd_reg;
    dist_t                 b_rd_reg;
    logic                  a_inf_reg;
    logic                  b_inf_reg;
    logic                  a_fwd_reg;
    logic                  b_fwd_reg;
    dist_t                 fwd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        a_rd_reg     <= mem[a_addr];
        b_rd_reg     <= mem[b_addr];
        fwd_data_reg <= wdata;
    end

    always_comb
    begin
        inf_next = inf_reg;
        if (init)
        begin
            inf_next = '1;
        end
        if (we)
        begin
            inf_next[waddr] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inf_reg   <= '1;
            a_inf_reg <= 1'b1;
            b_inf_reg <= 1'b1;
            a_fwd_reg <= 1'b0;
            b_fwd_reg <= 1'b0;
        end
        else
        begin
            inf_reg   <= inf_next;
            a_inf_reg <= inf_reg[a_addr];
            b_inf_reg <= inf_reg[b_addr];
            a_fwd_reg <= we && (waddr == a_addr);
            b_fwd_reg <= we && (waddr == b_addr);
        end
    end

    // a write at the read edge wins over the stale array data
    assign a_q = a_fwd_reg ? dentry_t'{inf: 1'b0, d: fwd_data_reg}
                           : dentry_t'{inf: a_inf_reg, d: a_rd_reg};
    assign b_q = b_fwd_reg ? dentry_t'{inf: 1'b0, d: fwd_data_reg}
                           : dentry_t'{inf: b_inf_reg, d: b_rd_reg};

endmodule

// ----- hdl/bfsd_relax.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfsd_relax
// edge relaxation: saturating sum and improvement test
// ----------------------------------------------------------------------------
module bfsd_relax (
    input  bfsd_pkg::issue_t  op,
    input  bfsd_pkg::wentry_t w,
    input  bfsd_pkg::dentry_t du,
    input  bfsd_pkg::dentry_t dv,
    output logic              improve,
    output bfsd_pkg::dist_t   sum
);
    import bfsd_pkg::*;

    localparam sum_t SUM_HI = SUM_W'(DIST_MAX);
    localparam sum_t SUM_LO = SUM_W'(DIST_MIN);

    sum_t sum_wide;

    always_comb
    begin
        sum_wide = SUM_W'($signed(du.d)) + SUM_W'($signed(w.w));
        if (sum_wide > SUM_HI)
        begin
            sum = DIST_MAX;
        end
        else if (sum_wide < SUM_LO)
        begin
            sum = DIST_MIN;
        end
        else
        begin
            sum = DIST_BITS'(sum_wide);
        end
        improve = op.valid && !du.inf && !w.none && (dv.inf || ($signed(dv.d) > $signed(sum)));
    end

endmodule

// ----- hdl/bellman_ford_shortest_distance.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bellman_ford_shortest_distance
// single-source shortest distance over a dense matrix, one result per load
// ----------------------------------------------------------------------------
// Matrix entries are taken one beat per cycle while the block is idle and
// written to a 256-entry weight ram. The beat with last_entry set starts the
// run: with n nodes in use the block does (n-1)*n*n relaxations plus n*n
// negative-cycle checks, one per cycle through the read-modify-write loop of
// the distance ram, after a setup step and followed by drain and result load;
// the result load is held back while an earlier result still waits. No
// entries are taken during a run. The result waits in an output register,
// and loading of the next matrix may proceed while it waits.
module bellman_ford_shortest_distance (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [bfsd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bfsd_pkg::CFG_W-1:0]       cfg_data,
    bfsd_in_if.sink                          items,
    bfsd_out_if.source                       results
);
    import bfsd_pkg::*;

    state_t  state_reg,  state_next;
    cfg_t    node_count_reg;
    cfg_t    source_node_reg;
    cfg_t    dest_node_reg;
    node_t   u_reg,      u_next;
    node_t   v_reg,      v_next;
    node_t   pass_reg,   pass_next;
    logic    check_reg,  check_next;
    logic    neg_reg,    neg_next;
    issue_t  s2_reg,     s2_next;
    logic    out_valid_reg;
    dist_t   out_dist_reg;
    logic    out_unreach_reg;
    logic    out_neg_reg;

    cnt_t    n_eff;
    node_t   n_last;
    logic    src_ok;
    logic    dest_ok;
    node_t   src_idx;
    node_t   dest_idx;
    logic    in_acc;
    logic    out_load;

    wentry_t w_q;
    dentry_t a_q;
    dentry_t b_q;
    node_t   a_addr;
    logic    dist_we;
    node_t   dist_waddr;
    dist_t   dist_wdata;
    logic    improve;
    dist_t   sum;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg  <= NODE_COUNT_RST;
            source_node_reg <= SOURCE_NODE_RST;
            dest_node_reg   <= DEST_NODE_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_NODE_COUNT:  node_count_reg  <= cfg_data;
                CFG_SOURCE_NODE: source_node_reg <= cfg_data;
                CFG_DEST_NODE:   dest_node_reg   <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        if (node_count_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (int'(node_count_reg) > MAX_NODES)
        begin
            n_eff = CNT_W'(MAX_NODES);
        end
        else
        begin
            n_eff = CNT_W'(node_count_reg);
        end
        n_last   = NODE_W'(n_eff - CNT_W'(1));
        src_ok   = (source_node_reg != '0) && (int'(source_node_reg) <= int'(n_eff));
        dest_ok  = (dest_node_reg != '0) && (int'(dest_node_reg) <= int'(n_eff));
        src_idx  = NODE_W'(source_node_reg - CFG_W'(1));
        dest_idx = NODE_W'(dest_node_reg - CFG_W'(1));
    end

    assign items.ready = (state_reg == ST_IDLE);
    assign in_acc      = items.valid && items.ready;

    // weight store
    bfsd_ram #(
        .WIDTH ($bits(wentry_t)),
        .DEPTH (MAX_NODES * MAX_NODES)
    ) u_weight_ram (
        .clk   (clk),
        .we    (in_acc),
        .waddr ({items.row_index, items.col_index}),
        .wdata ({items.no_edge, items.edge_weight}),
        .raddr ({u_reg, v_reg}),
        .rdata (w_q)
    );

    // distance store
    assign a_addr = (state_reg == ST_RUN) ? v_reg : dest_idx;

    always_comb
    begin
        if (state_reg == ST_INIT)
        begin
            dist_we    = src_ok;
            dist_waddr = src_idx;
            dist_wdata = '0;
        end
        else
        begin
            dist_we    = improve && !s2_reg.check;
            dist_waddr = s2_reg.v;
            dist_wdata = sum;
        end
    end

    bfsd_dist_ram u_dist_ram (
        .clk    (clk),
        .rst_n  (rst_n),
        .init   (state_reg == ST_INIT),
        .a_addr (a_addr),
        .b_addr (u_reg),
        .we     (dist_we),
        .waddr  (dist_waddr),
        .wdata  (dist_wdata),
        .a_q    (a_q),
        .b_q    (b_q)
    );

    bfsd_relax u_relax (
        .op      (s2_reg),
        .w       (w_q),
        .du      (b_q),
        .dv      (a_q),
        .improve (improve),
        .sum     (sum)
    );

    // sequencer
    assign out_load = (state_reg == ST_RESULT) && (!out_valid_reg || results.ready);

    always_comb
    begin
        state_next = state_reg;
        u_next     = u_reg;
        v_next     = v_reg;
        pass_next  = pass_reg;
        check_next = check_reg;
        neg_next   = neg_reg;
        s2_next    = '0;
        if (improve && s2_reg.check)
        begin
            neg_next = 1'b1;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && items.last_entry)
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                u_next     = '0;
                v_next     = '0;
                pass_next  = '0;
                check_next = (n_last == '0);
                neg_next   = 1'b0;
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                s2_next = issue_t'{valid: 1'b1, check: check_reg, u: u_reg, v: v_reg};
                if (v_reg == n_last)
                begin
                    v_next = '0;
                    if (u_reg == n_last)
                    begin
                        u_next = '0;
                        if (check_reg)
                        begin
                            state_next = ST_DRAIN;
                        end
                        else if (pass_reg == NODE_W'(n_last - NODE_W'(1)))
                        begin
                            check_next = 1'b1;
                        end
                        else
                        begin
                            pass_next = pass_reg + NODE_W'(1);
                        end
                    end
                    else
                    begin
                        u_next = u_reg + NODE_W'(1);
                    end
                end
                else
                begin
                    v_next = v_reg + NODE_W'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            u_reg     <= '0;
            v_reg     <= '0;
            pass_reg  <= '0;
            check_reg <= 1'b0;
            neg_reg   <= 1'b0;
            s2_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            u_reg     <= u_next;
            v_reg     <= v_next;
            pass_reg  <= pass_next;
            check_reg <= check_next;
            neg_reg   <= neg_next;
            s2_reg    <= s2_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (neg_reg)
            begin
                out_dist_reg    <= DIST_MIN;
                out_unreach_reg <= 1'b0;
                out_neg_reg     <= 1'b1;
            end
            else if (!dest_ok || a_q.inf)
            begin
                out_dist_reg    <= '0;
                out_unreach_reg <= 1'b1;
                out_neg_reg     <= 1'b0;
            end
            else
            begin
                out_dist_reg    <= a_q.d;
                out_unreach_reg <= 1'b0;
                out_neg_reg     <= 1'b0;
            end
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.distance       = out_dist_reg;
    assign results.unreachable    = out_unreach_reg;
    assign results.negative_cycle = out_neg_reg;

`include "bellman_ford_shortest_distance_assert.svh"

    `BFSD_ASSERT(a_no_relax_while_loading, items.ready |-> !s2_reg.valid, "relaxation in flight while loading")
    `BFSD_ASSERT(a_result_from_result_state, $rose(out_valid_reg) |-> $past(state_reg == ST_RESULT), "result beat without a finished run")
    `BFSD_ASSERT(a_no_write_in_check, (s2_reg.valid && s2_reg.check) |-> !dist_we, "distance written during cycle check")
    `BFSD_ASSERT_ALWAYS(a_flags_exclusive, !(out_valid_reg && out_neg_reg && out_unreach_reg), "negative cycle reported unreachable")

endmodule
